// ----- hdl/obm_pkg.sv -----
// obm_pkg: shared types, field widths, operation and status codes for the order book matcher
// no dependencies; imported by every module of the block
package obm_pkg;

    localparam int PRODUCT_W = 8;
    localparam int PRICE_W = 20;
    localparam int QTY_W = 20;
    localparam int TRADER_W = 8;
    localparam int OID_W = 20;
    localparam int PCOUNT_W = 9;
    localparam int SLOT_W = 8;

    localparam int DEF_ORDER_SLOTS = 256;
    localparam int DEF_PRICE_LIMIT = 1000000;
    localparam int DEF_QUANTITY_LIMIT = 1000000;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 9'd256;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_MATCH = 3'd1;
    localparam logic [2:0] FN_CANCEL = 3'd2;
    localparam logic [2:0] FN_AMEND = 3'd3;
    localparam logic [2:0] FN_EXISTS = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;

    localparam logic [0:0] REG_PROD_LIMIT = 1'b0;

    typedef struct packed {
        logic [2:0]           func;
        logic                 is_buy;
        logic [PRODUCT_W-1:0] prod_code;
        logic [PRICE_W-1:0]   price;
        logic [QTY_W-1:0]     quantity;
        logic [TRADER_W-1:0]  trader_code;
        logic [OID_W-1:0]     order_num;
    } t_cmd;

    typedef struct packed {
        logic [2:0]           status;
        logic [SLOT_W-1:0]    slot;
        logic                 hit_is_buy;
        logic [PRODUCT_W-1:0] hit_product;
        logic [PRICE_W-1:0]   hit_price;
        logic [QTY_W-1:0]     hit_quantity;
        logic [TRADER_W-1:0]  hit_trader;
        logic [OID_W-1:0]     hit_order_num;
    } t_result;

    typedef struct packed {
        logic                 is_buy;
        logic [PRODUCT_W-1:0] product;
        logic [PRICE_W-1:0]   price;
        logic [QTY_W-1:0]     quantity;
    } t_terms;

    typedef struct packed {
        logic [TRADER_W-1:0] trader;
        logic [OID_W-1:0]    order_num;
    } t_owner;

    typedef struct packed {
        t_terms terms;
        t_owner owner;
    } t_entry;

    function automatic logic terms_ok(t_terms t, logic [PCOUNT_W-1:0] pcount,
                                      logic [PRICE_W:0] plim, logic [QTY_W:0] qlim);
        return ({1'b0, t.product} < pcount) && (t.price != '0) &&
               ({1'b0, t.price} < plim) && (t.quantity != '0) &&
               ({1'b0, t.quantity} < qlim);
    endfunction

endpackage

// ----- hdl/obm_cfg.sv -----
// obm_cfg: apb register block holding the product count
// depends on obm_pkg
module obm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [obm_pkg::PCOUNT_W-1:0]  o_prod_limit
);
    import obm_pkg::*;

    logic [PCOUNT_W-1:0] r_prod_limit;
    logic                w_sel_pc;

    assign w_sel_pc = (paddr[2] == REG_PROD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_limit <= PCOUNT_RESET;
        end else if (psel && penable && pwrite && w_sel_pc) begin
            r_prod_limit <= pwdata[PCOUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = w_sel_pc ? {{(32-PCOUNT_W){1'b0}}, r_prod_limit} : 32'd0;
    assign o_prod_limit = r_prod_limit;

endmodule

// ----- hdl/obm_engine.sv -----
// obm_engine: slot memories, used bits and the sequencer that walks the linked price list
// depends on obm_pkg
module obm_engine #(
    parameter int ORDER_SLOTS = obm_pkg::DEF_ORDER_SLOTS,
    parameter int PRICE_LIMIT = obm_pkg::DEF_PRICE_LIMIT,
    parameter int QUANTITY_LIMIT = obm_pkg::DEF_QUANTITY_LIMIT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  obm_pkg::t_cmd                i_cmd,
    input  logic [obm_pkg::PCOUNT_W-1:0] i_prod_limit,
    output logic                         o_busy,
    output logic                         o_done,
    output obm_pkg::t_result             o_result
);
    import obm_pkg::*;

    localparam int SW = $clog2(ORDER_SLOTS);
    localparam int LW = $clog2(ORDER_SLOTS + 1);
    localparam logic [LW-1:0] NONE = LW'(ORDER_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(ORDER_SLOTS - 1);
    localparam logic [PRICE_W:0] PLIM = (PRICE_W + 1)'(PRICE_LIMIT);
    localparam logic [QTY_W:0] QLIM = (QTY_W + 1)'(QUANTITY_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_PLACE, S_WALK, S_UNLINK, S_LINK_SELF, S_LINK_PREV
    } t_state;

    t_entry          mem_a [ORDER_SLOTS];
    logic [LW-1:0]   mem_l [ORDER_SLOTS];
    t_entry          r_rd_a;
    logic [LW-1:0]   r_rd_l;

    t_state           r_state;
    t_cmd             r_cmd;
    logic             r_ins;
    logic [LW-1:0]    r_node;
    logic [LW-1:0]    r_prev;
    logic [LW-1:0]    r_steps;
    logic [SW-1:0]    r_slot;
    logic [SW-1:0]    r_idx;
    t_terms           r_terms;
    logic             r_best_ok;
    logic [SW-1:0]    r_best_slot;
    t_entry           r_best;
    logic [LW-1:0]    r_head;
    logic [ORDER_SLOTS-1:0] r_used;
    logic             r_done;
    t_result          r_res;

    logic [SW-1:0]    w_raddr;
    logic             w_wa_en;
    logic [SW-1:0]    w_wa_addr;
    t_entry           w_wa_data;
    logic             w_wl_en;
    logic [SW-1:0]    w_wl_addr;
    logic [LW-1:0]    w_wl_data;
    t_owner           w_owner;
    t_terms           w_in_terms;
    t_terms           w_amend_terms;
    logic [LW-1:0]    w_steps_n;
    logic             w_last;
    logic [LW-1:0]    w_unlink_head;
    logic             w_mt;
    logic             w_sell_hit;
    logic             w_buy_hit;
    logic             w_ex_hit;
    logic             w_brk;

    function automatic t_result mk_res(logic [2:0] st, logic [SW-1:0] s, t_entry e,
                                       logic hit);
        t_result          r;
        logic [SW+7:0]    ext;
        ext = (SW + 8)'(s);
        r = '0;
        r.status = st;
        r.slot = ext[7:0];
        if (hit) begin
            r.hit_is_buy = e.terms.is_buy;
            r.hit_product = e.terms.product;
            r.hit_price = e.terms.price;
            r.hit_quantity = e.terms.quantity;
            r.hit_trader = e.owner.trader;
            r.hit_order_num = e.owner.order_num;
        end
        return r;
    endfunction

    // memories with write-to-read forwarding
    always_ff @(posedge i_clk) begin
        if (w_wa_en) begin
            mem_a[w_wa_addr] <= w_wa_data;
        end
        if (w_wl_en) begin
            mem_l[w_wl_addr] <= w_wl_data;
        end
        r_rd_a <= (w_wa_en && w_wa_addr == w_raddr) ? w_wa_data : mem_a[w_raddr];
        r_rd_l <= (w_wl_en && w_wl_addr == w_raddr) ? w_wl_data : mem_l[w_raddr];
    end

    assign w_owner = '{trader: r_cmd.trader_code, order_num: r_cmd.order_num};
    assign w_in_terms = '{is_buy: i_cmd.is_buy, product: i_cmd.prod_code,
                          price: i_cmd.price, quantity: i_cmd.quantity};
    assign w_amend_terms = '{is_buy: r_rd_a.terms.is_buy, product: r_rd_a.terms.product,
                             price: r_cmd.price, quantity: r_cmd.quantity};
    assign w_steps_n = r_steps + 1'b1;
    assign w_last = (r_rd_l >= NONE) || (w_steps_n >= NONE);
    assign w_unlink_head = (r_prev == NONE) ? r_node : r_head;

    assign w_mt = (r_rd_a.terms.product == r_cmd.prod_code) && (r_rd_a.terms.quantity != '0);
    assign w_sell_hit = w_mt && r_cmd.is_buy && !r_rd_a.terms.is_buy &&
                        (r_rd_a.terms.price <= r_cmd.price);
    assign w_buy_hit = w_mt && !r_cmd.is_buy && r_rd_a.terms.is_buy &&
                       (r_rd_a.terms.price >= r_cmd.price);
    assign w_ex_hit = (r_rd_a.terms.is_buy == r_cmd.is_buy) &&
                      (r_rd_a.terms.product == r_cmd.prod_code) &&
                      (r_rd_a.terms.price == r_cmd.price) && (r_rd_a.terms.quantity != '0);
    assign w_brk = r_terms.is_buy ? (r_rd_a.terms.price < r_terms.price)
                                  : (r_rd_a.terms.price <= r_terms.price);

    always_comb begin
        unique case (r_state)
            S_IDLE:   w_raddr = r_head[SW-1:0];
            S_PLACE:  w_raddr = r_head[SW-1:0];
            S_WALK:   w_raddr = r_rd_l[SW-1:0];
            S_UNLINK: w_raddr = w_unlink_head[SW-1:0];
            default:  w_raddr = '0;
        endcase
    end

    always_comb begin
        w_wa_en = (r_state == S_PLACE) || (r_state == S_UNLINK && r_cmd.func == FN_AMEND);
        w_wa_addr = r_slot;
        w_wa_data = '{terms: r_terms, owner: w_owner};
        w_wl_en = 1'b0;
        w_wl_addr = r_prev[SW-1:0];
        w_wl_data = r_node;
        unique case (r_state)
            S_UNLINK: begin
                w_wl_en = (r_prev != NONE);
            end
            S_LINK_SELF: begin
                w_wl_en = 1'b1;
                w_wl_addr = r_slot;
            end
            S_LINK_PREV: begin
                w_wl_en = 1'b1;
                w_wl_data = LW'(r_slot);
            end
            default: begin
                w_wl_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
            r_head <= NONE;
            r_used <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        r_terms <= w_in_terms;
                        r_ins <= 1'b0;
                        r_node <= r_head;
                        r_prev <= NONE;
                        r_steps <= '0;
                        r_best_ok <= 1'b0;
                        r_idx <= '0;
                        priority if (i_cmd.func == FN_ADD) begin
                            if (terms_ok(w_in_terms, i_prod_limit, PLIM, QLIM)) begin
                                r_state <= S_SCAN;
                            end else begin
                                r_done <= 1'b1;
                                r_res <= mk_res(ST_INVALID, '0, r_rd_a, 1'b0);
                            end
                        end else if (i_cmd.func == FN_MATCH || i_cmd.func == FN_CANCEL ||
                                     i_cmd.func == FN_AMEND || i_cmd.func == FN_EXISTS) begin
                            if (r_head == NONE) begin
                                r_done <= 1'b1;
                                r_res <= mk_res(ST_NOT_FOUND, '0, r_rd_a, 1'b0);
                            end else begin
                                r_state <= S_WALK;
                            end
                        end else begin
                            r_done <= 1'b1;
                            r_res <= mk_res(ST_INVALID, '0, r_rd_a, 1'b0);
                        end
                    end
                end
                S_SCAN: begin
                    priority if (!r_used[r_idx]) begin
                        r_slot <= r_idx;
                        r_state <= S_PLACE;
                    end else if (r_idx == LAST_IDX) begin
                        r_done <= 1'b1;
                        r_res <= mk_res(ST_FULL, '0, r_rd_a, 1'b0);
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_PLACE: begin
                    r_used[r_slot] <= 1'b1;
                    r_ins <= 1'b1;
                    r_node <= r_head;
                    r_prev <= NONE;
                    r_steps <= '0;
                    r_state <= (r_head == NONE) ? S_LINK_SELF : S_WALK;
                end
                S_WALK: begin
                    if (r_ins) begin
                        if (w_brk) begin
                            r_state <= S_LINK_SELF;
                        end else begin
                            r_prev <= r_node;
                            r_node <= r_rd_l;
                            r_steps <= w_steps_n;
                            if (w_last) begin
                                r_state <= S_LINK_SELF;
                            end
                        end
                    end else begin
                        unique case (r_cmd.func)
                            FN_MATCH: begin
                                if (w_sell_hit) begin
                                    r_best_ok <= 1'b1;
                                    r_best_slot <= r_node[SW-1:0];
                                    r_best <= r_rd_a;
                                end
                                priority if (w_buy_hit) begin
                                    r_done <= 1'b1;
                                    r_res <= mk_res(ST_OK, r_node[SW-1:0], r_rd_a, 1'b1);
                                    r_state <= S_IDLE;
                                end else if (w_last) begin
                                    r_done <= 1'b1;
                                    r_state <= S_IDLE;
                                    priority if (w_sell_hit) begin
                                        r_res <= mk_res(ST_OK, r_node[SW-1:0], r_rd_a, 1'b1);
                                    end else if (r_best_ok) begin
                                        r_res <= mk_res(ST_OK, r_best_slot, r_best, 1'b1);
                                    end else begin
                                        r_res <= mk_res(ST_NOT_FOUND, '0, r_rd_a, 1'b0);
                                    end
                                end else begin
                                    r_prev <= r_node;
                                    r_node <= r_rd_l;
                                    r_steps <= w_steps_n;
                                end
                            end
                            FN_EXISTS: begin
                                priority if (w_ex_hit) begin
                                    r_done <= 1'b1;
                                    r_res <= mk_res(ST_OK, '0, r_rd_a, 1'b0);
                                    r_state <= S_IDLE;
                                end else if (w_last) begin
                                    r_done <= 1'b1;
                                    r_res <= mk_res(ST_NOT_FOUND, '0, r_rd_a, 1'b0);
                                    r_state <= S_IDLE;
                                end else begin
                                    r_prev <= r_node;
                                    r_node <= r_rd_l;
                                    r_steps <= w_steps_n;
                                end
                            end
                            FN_CANCEL, FN_AMEND: begin
                                priority if (r_rd_a.owner == w_owner) begin
                                    priority if (!terms_ok(r_rd_a.terms, i_prod_limit,
                                                           PLIM, QLIM) ||
                                                 (r_cmd.func == FN_AMEND &&
                                                  !terms_ok(w_amend_terms, i_prod_limit,
                                                            PLIM, QLIM))) begin
                                        r_done <= 1'b1;
                                        r_res <= mk_res(ST_INVALID, '0, r_rd_a, 1'b0);
                                        r_state <= S_IDLE;
                                    end else begin
                                        r_slot <= r_node[SW-1:0];
                                        r_best <= r_rd_a;
                                        r_node <= r_rd_l;
                                        r_terms <= w_amend_terms;
                                        r_state <= S_UNLINK;
                                    end
                                end else if (w_last) begin
                                    r_done <= 1'b1;
                                    r_res <= mk_res(ST_NOT_FOUND, '0, r_rd_a, 1'b0);
                                    r_state <= S_IDLE;
                                end else begin
                                    r_prev <= r_node;
                                    r_node <= r_rd_l;
                                    r_steps <= w_steps_n;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                                r_res <= mk_res(ST_INVALID, '0, r_rd_a, 1'b0);
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_UNLINK: begin
                    if (r_prev == NONE) begin
                        r_head <= r_node;
                    end
                    if (r_cmd.func == FN_CANCEL) begin
                        r_used[r_slot] <= 1'b0;
                        r_done <= 1'b1;
                        r_res <= mk_res(ST_OK, r_slot, r_best, 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_ins <= 1'b1;
                        r_node <= w_unlink_head;
                        r_prev <= NONE;
                        r_steps <= '0;
                        r_state <= (w_unlink_head == NONE) ? S_LINK_SELF : S_WALK;
                    end
                end
                S_LINK_SELF: begin
                    if (r_prev == NONE) begin
                        r_head <= LW'(r_slot);
                        r_done <= 1'b1;
                        r_res <= mk_res(ST_OK, r_slot, r_rd_a, 1'b0);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_LINK_PREV;
                    end
                end
                S_LINK_PREV: begin
                    r_done <= 1'b1;
                    r_res <= mk_res(ST_OK, r_slot, r_rd_a, 1'b0);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;

endmodule

// ----- hdl/order_book_matcher.sv -----
// order_book_matcher: top level of the fixed-slot limit order book
// depends on obm_pkg, obm_cfg and obm_engine
//
// channel    direction  handshake              payload
// command    in         start && !busy         i_cmd (obm_pkg::t_cmd)
// result     out        o_done, one cycle      o_result (obm_pkg::t_result)
// config     in         apb write, pready = 1  pwdata[8:0] at byte address 0
//
// one command at a time; a list walk visits one linked order per cycle
// the steps of each command, in order:
// add: free-slot scan, place, walk and link; on a full book the scan alone
// match, exists: list walk; cancel: list walk, unlink; amend: list walk, unlink, walk and link
// the result strobe is registered together with the return to idle, so busy is already low
// synchronous reset empties the book at once; results cannot be held off
module order_book_matcher #(
    parameter int ORDER_SLOTS = obm_pkg::DEF_ORDER_SLOTS,
    parameter int PRICE_LIMIT = obm_pkg::DEF_PRICE_LIMIT,
    parameter int QUANTITY_LIMIT = obm_pkg::DEF_QUANTITY_LIMIT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  obm_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output obm_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import obm_pkg::*;

    logic [PCOUNT_W-1:0] w_prod_limit;

    obm_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_prod_limit (w_prod_limit)
    );

    obm_engine #(
        .ORDER_SLOTS    (ORDER_SLOTS),
        .PRICE_LIMIT    (PRICE_LIMIT),
        .QUANTITY_LIMIT (QUANTITY_LIMIT)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_prod_limit (w_prod_limit),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule

// ----- hdl/obm_checker.sv -----
// obm_checker: port-level checks of the order book matcher, bound to the top level
// depends on obm_pkg and order_book_matcher
module obm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input obm_pkg::t_result o_result,
    input logic             pready
);
    import obm_pkg::*;

    // an accepted transaction either finishes at once or holds the block busy
    a_accept_progress: assert property (@(posedge i_clk)
        (i_rst_n && start && !busy) |=> (busy || o_done))
        else $error("accepted transaction neither busy nor done");

    // a result only shows when the block has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // failed transactions report no slot and no hit
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.slot == '0 && o_result.hit_price == '0 &&
         o_result.hit_quantity == '0 && o_result.hit_order_num == '0))
        else $error("failed transaction carries payload");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_NOT_FOUND ||
                    o_result.status == ST_INVALID || o_result.status == ST_FULL))
        else $error("status code out of range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind order_book_matcher obm_checker u_obm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result),
    .pready   (pready)
);
